>>> hw/rtl/kf_pkg.sv
// shared types, constants and the operation sequence of the kalman filter core
package kf_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned MEM_DEPTH = 23;
  localparam int unsigned PC_W      = 7;
  localparam int unsigned DVD_W     = WORD_W + FRAC_W;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned CFG_IDX_W = 8;

  // first step of the tracking sequence
  localparam logic [PC_W-1:0] PC_TRACK = 7'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR   = 8'd3;

  // operand and destination codes: scratch memory entries, then fixed sources
  localparam logic [ADDR_W-1:0] A_PX   = 5'd0;
  localparam logic [ADDR_W-1:0] A_VX   = 5'd1;
  localparam logic [ADDR_W-1:0] A_P0   = 5'd2;
  localparam logic [ADDR_W-1:0] A_P1   = 5'd3;
  localparam logic [ADDR_W-1:0] A_P2   = 5'd4;
  localparam logic [ADDR_W-1:0] A_P3   = 5'd5;
  localparam logic [ADDR_W-1:0] A_B00  = 5'd6;
  localparam logic [ADDR_W-1:0] A_B01  = 5'd7;
  localparam logic [ADDR_W-1:0] A_S00  = 5'd8;
  localparam logic [ADDR_W-1:0] A_S11  = 5'd9;
  localparam logic [ADDR_W-1:0] A_DET  = 5'd10;
  localparam logic [ADDR_W-1:0] A_T0   = 5'd11;
  localparam logic [ADDR_W-1:0] A_T1   = 5'd12;
  localparam logic [ADDR_W-1:0] A_K00  = 5'd13;
  localparam logic [ADDR_W-1:0] A_K01  = 5'd14;
  localparam logic [ADDR_W-1:0] A_K10  = 5'd15;
  localparam logic [ADDR_W-1:0] A_K11  = 5'd16;
  localparam logic [ADDR_W-1:0] A_Y0   = 5'd17;
  localparam logic [ADDR_W-1:0] A_Y1   = 5'd18;
  localparam logic [ADDR_W-1:0] A_N00  = 5'd19;
  localparam logic [ADDR_W-1:0] A_N01  = 5'd20;
  localparam logic [ADDR_W-1:0] A_N10  = 5'd21;
  localparam logic [ADDR_W-1:0] A_N11  = 5'd22;
  localparam logic [ADDR_W-1:0] A_ZERO = 5'd23;
  localparam logic [ADDR_W-1:0] A_DT   = 5'd24;
  localparam logic [ADDR_W-1:0] A_Q    = 5'd25;
  localparam logic [ADDR_W-1:0] A_R    = 5'd26;
  localparam logic [ADDR_W-1:0] A_IV   = 5'd27;
  localparam logic [ADDR_W-1:0] A_Z0   = 5'd28;
  localparam logic [ADDR_W-1:0] A_Z1   = 5'd29;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MSAT,
    ST_DIV,
    ST_WB,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src_a;
    logic [ADDR_W-1:0] src_b;
    logic              fin;
    logic              chk;
  } uop_t;

  typedef struct packed {
    logic              load_in;
    logic              rd_en;
    logic [ADDR_W-1:0] src_a;
    logic [ADDR_W-1:0] src_b;
    logic              exec;
    op_t               op;
    logic              msat;
    logic              div_step;
    logic              wb;
    logic [ADDR_W-1:0] dst;
    logic              out_load;
    logic              first;
    logic              singular;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic nonpos;
    logic out_free;
  } status_t;

  function automatic uop_t mk(op_t op, logic [ADDR_W-1:0] d, logic [ADDR_W-1:0] a,
                              logic [ADDR_W-1:0] b, logic fin, logic chk);
    uop_t u;
    u.op    = op;
    u.dst   = d;
    u.src_a = a;
    u.src_b = b;
    u.fin   = fin;
    u.chk   = chk;
    return u;
  endfunction

  // operation sequence: load on the first word, then predict and update
  function automatic uop_t rom(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      7'd0:  u = mk(OP_ADD, A_PX,  A_Z0,   A_ZERO, 1'b0, 1'b0);
      7'd1:  u = mk(OP_ADD, A_VX,  A_Z1,   A_ZERO, 1'b0, 1'b0);
      7'd2:  u = mk(OP_ADD, A_P0,  A_IV,   A_ZERO, 1'b0, 1'b0);
      7'd3:  u = mk(OP_ADD, A_P1,  A_ZERO, A_ZERO, 1'b0, 1'b0);
      7'd4:  u = mk(OP_ADD, A_P2,  A_ZERO, A_ZERO, 1'b0, 1'b0);
      7'd5:  u = mk(OP_ADD, A_P3,  A_IV,   A_ZERO, 1'b1, 1'b0);
      // predict
      7'd6:  u = mk(OP_MUL, A_T0,  A_DT,   A_VX,   1'b0, 1'b0);
      7'd7:  u = mk(OP_ADD, A_PX,  A_PX,   A_T0,   1'b0, 1'b0);
      7'd8:  u = mk(OP_MUL, A_T0,  A_DT,   A_P2,   1'b0, 1'b0);
      7'd9:  u = mk(OP_ADD, A_B00, A_P0,   A_T0,   1'b0, 1'b0);
      7'd10: u = mk(OP_MUL, A_T0,  A_DT,   A_P3,   1'b0, 1'b0);
      7'd11: u = mk(OP_ADD, A_B01, A_P1,   A_T0,   1'b0, 1'b0);
      7'd12: u = mk(OP_MUL, A_T0,  A_DT,   A_B01,  1'b0, 1'b0);
      7'd13: u = mk(OP_ADD, A_T0,  A_B00,  A_T0,   1'b0, 1'b0);
      7'd14: u = mk(OP_ADD, A_P0,  A_T0,   A_Q,    1'b0, 1'b0);
      7'd15: u = mk(OP_ADD, A_P1,  A_B01,  A_ZERO, 1'b0, 1'b0);
      7'd16: u = mk(OP_MUL, A_T0,  A_DT,   A_P3,   1'b0, 1'b0);
      7'd17: u = mk(OP_ADD, A_P2,  A_P2,   A_T0,   1'b0, 1'b0);
      7'd18: u = mk(OP_ADD, A_P3,  A_P3,   A_Q,    1'b0, 1'b0);
      // innovation covariance and its determinant
      7'd19: u = mk(OP_ADD, A_S00, A_P0,   A_R,    1'b0, 1'b0);
      7'd20: u = mk(OP_ADD, A_S11, A_P3,   A_R,    1'b0, 1'b0);
      7'd21: u = mk(OP_MUL, A_T0,  A_S00,  A_S11,  1'b0, 1'b0);
      7'd22: u = mk(OP_MUL, A_T1,  A_P1,   A_P2,   1'b0, 1'b0);
      7'd23: u = mk(OP_SUB, A_DET, A_T0,   A_T1,   1'b0, 1'b1);
      // gain
      7'd24: u = mk(OP_MUL, A_T0,  A_P0,   A_S11,  1'b0, 1'b0);
      7'd25: u = mk(OP_MUL, A_T1,  A_P1,   A_P2,   1'b0, 1'b0);
      7'd26: u = mk(OP_SUB, A_T0,  A_T0,   A_T1,   1'b0, 1'b0);
      7'd27: u = mk(OP_DIV, A_K00, A_T0,   A_DET,  1'b0, 1'b0);
      7'd28: u = mk(OP_MUL, A_T0,  A_P1,   A_S00,  1'b0, 1'b0);
      7'd29: u = mk(OP_MUL, A_T1,  A_P0,   A_P1,   1'b0, 1'b0);
      7'd30: u = mk(OP_SUB, A_T0,  A_T0,   A_T1,   1'b0, 1'b0);
      7'd31: u = mk(OP_DIV, A_K01, A_T0,   A_DET,  1'b0, 1'b0);
      7'd32: u = mk(OP_MUL, A_T0,  A_P2,   A_S11,  1'b0, 1'b0);
      7'd33: u = mk(OP_MUL, A_T1,  A_P3,   A_P2,   1'b0, 1'b0);
      7'd34: u = mk(OP_SUB, A_T0,  A_T0,   A_T1,   1'b0, 1'b0);
      7'd35: u = mk(OP_DIV, A_K10, A_T0,   A_DET,  1'b0, 1'b0);
      7'd36: u = mk(OP_MUL, A_T0,  A_P3,   A_S00,  1'b0, 1'b0);
      7'd37: u = mk(OP_MUL, A_T1,  A_P2,   A_P1,   1'b0, 1'b0);
      7'd38: u = mk(OP_SUB, A_T0,  A_T0,   A_T1,   1'b0, 1'b0);
      7'd39: u = mk(OP_DIV, A_K11, A_T0,   A_DET,  1'b0, 1'b0);
      // state update
      7'd40: u = mk(OP_SUB, A_Y0,  A_Z0,   A_PX,   1'b0, 1'b0);
      7'd41: u = mk(OP_SUB, A_Y1,  A_Z1,   A_VX,   1'b0, 1'b0);
      7'd42: u = mk(OP_MUL, A_T0,  A_K00,  A_Y0,   1'b0, 1'b0);
      7'd43: u = mk(OP_MUL, A_T1,  A_K01,  A_Y1,   1'b0, 1'b0);
      7'd44: u = mk(OP_ADD, A_T0,  A_T0,   A_T1,   1'b0, 1'b0);
      7'd45: u = mk(OP_ADD, A_PX,  A_PX,   A_T0,   1'b0, 1'b0);
      7'd46: u = mk(OP_MUL, A_T0,  A_K10,  A_Y0,   1'b0, 1'b0);
      7'd47: u = mk(OP_MUL, A_T1,  A_K11,  A_Y1,   1'b0, 1'b0);
      7'd48: u = mk(OP_ADD, A_T0,  A_T0,   A_T1,   1'b0, 1'b0);
      7'd49: u = mk(OP_ADD, A_VX,  A_VX,   A_T0,   1'b0, 1'b0);
      // covariance update
      7'd50: u = mk(OP_MUL, A_T0,  A_K00,  A_P0,   1'b0, 1'b0);
      7'd51: u = mk(OP_MUL, A_T1,  A_K01,  A_P2,   1'b0, 1'b0);
      7'd52: u = mk(OP_ADD, A_T0,  A_T0,   A_T1,   1'b0, 1'b0);
      7'd53: u = mk(OP_SUB, A_N00, A_P0,   A_T0,   1'b0, 1'b0);
      7'd54: u = mk(OP_MUL, A_T0,  A_K00,  A_P1,   1'b0, 1'b0);
      7'd55: u = mk(OP_MUL, A_T1,  A_K01,  A_P3,   1'b0, 1'b0);
      7'd56: u = mk(OP_ADD, A_T0,  A_T0,   A_T1,   1'b0, 1'b0);
      7'd57: u = mk(OP_SUB, A_N01, A_P1,   A_T0,   1'b0, 1'b0);
      7'd58: u = mk(OP_MUL, A_T0,  A_K10,  A_P0,   1'b0, 1'b0);
      7'd59: u = mk(OP_MUL, A_T1,  A_K11,  A_P2,   1'b0, 1'b0);
      7'd60: u = mk(OP_ADD, A_T0,  A_T0,   A_T1,   1'b0, 1'b0);
      7'd61: u = mk(OP_SUB, A_N10, A_P2,   A_T0,   1'b0, 1'b0);
      7'd62: u = mk(OP_MUL, A_T0,  A_K10,  A_P1,   1'b0, 1'b0);
      7'd63: u = mk(OP_MUL, A_T1,  A_K11,  A_P3,   1'b0, 1'b0);
      7'd64: u = mk(OP_ADD, A_T0,  A_T0,   A_T1,   1'b0, 1'b0);
      7'd65: u = mk(OP_SUB, A_N11, A_P3,   A_T0,   1'b0, 1'b0);
      7'd66: u = mk(OP_ADD, A_P0,  A_N00,  A_ZERO, 1'b0, 1'b0);
      7'd67: u = mk(OP_ADD, A_P1,  A_N01,  A_ZERO, 1'b0, 1'b0);
      7'd68: u = mk(OP_ADD, A_P2,  A_N10,  A_ZERO, 1'b0, 1'b0);
      7'd69: u = mk(OP_ADD, A_P3,  A_N11,  A_ZERO, 1'b1, 1'b0);
      default: u = mk(OP_ADD, A_T0, A_ZERO, A_ZERO, 1'b1, 1'b0);
    endcase
    return u;
  endfunction

endpackage

>>> hw/rtl/kf_ctrl.sv
// sequencer that walks the operation list and drives the datapath
module kf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  output logic            idle,
  output kf_pkg::cmd_t    cmd,
  input  kf_pkg::status_t status
);
  import kf_pkg::*;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            started_r, started_nxt;
  logic            first_r, first_nxt;
  logic            sing_r, sing_nxt;
  uop_t            uop;

  assign uop  = rom(pc_r);
  assign idle = (state_r == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pc_r      <= '0;
      started_r <= 1'b0;
      first_r   <= 1'b0;
      sing_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pc_r      <= pc_nxt;
      started_r <= started_nxt;
      first_r   <= first_nxt;
      sing_r    <= sing_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    pc_nxt       = pc_r;
    started_nxt  = started_r;
    first_nxt    = first_r;
    sing_nxt     = sing_r;
    cmd          = '0;
    cmd.src_a    = uop.src_a;
    cmd.src_b    = uop.src_b;
    cmd.op       = uop.op;
    cmd.dst      = uop.dst;
    cmd.first    = first_r;
    cmd.singular = sing_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load_in = 1'b1;
          pc_nxt      = started_r ? PC_TRACK : '0;
          first_nxt   = !started_r;
          sing_nxt    = 1'b0;
          started_nxt = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (uop.op)
          OP_MUL:  state_nxt = ST_MSAT;
          OP_DIV:  state_nxt = ST_DIV;
          default: state_nxt = ST_WB;
        endcase
      end
      ST_MSAT: begin
        cmd.msat  = 1'b1;
        state_nxt = ST_WB;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        cmd.wb = 1'b1;
        state_nxt = ST_WB;
        if (uop.fin) begin
          state_nxt = ST_OUT;
        end else begin
          pc_nxt    = pc_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_OUT: begin
        // a non-positive determinant ends the sequence early
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // determinant check, seen on the cycle after its write-back
    if (state_r == ST_READ && uop.chk == 1'b0 && pc_r != '0 && rom(pc_r - 1'b1).chk
        && status.nonpos) begin
      cmd.rd_en = 1'b0;
      sing_nxt  = 1'b1;
      state_nxt = ST_OUT;
    end
  end

endmodule

>>> hw/rtl/kf_dp.sv
// datapath: scratch memory, saturating adder, shared multiplier and serial divider
module kf_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kf_pkg::cmd_t                   cmd,
  output kf_pkg::status_t                status,
  input  logic [2*kf_pkg::WORD_W-1:0]    in_word,
  input  logic                           cfg_we,
  input  logic [kf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [kf_pkg::WORD_W-1:0]      cfg_wdata,
  output logic [4*kf_pkg::WORD_W-1:0]    out_word,
  output logic [1:0]                     out_flags,
  output logic                           out_valid,
  input  logic                           out_ready
);
  import kf_pkg::*;

  localparam logic [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};

  // configuration
  logic [15:0]       dt_r;
  logic [WORD_W-2:0] q_r, r_r, iv_r;

  // scratch memory and fixed operands
  logic signed [WORD_W-1:0] mem_r [MEM_DEPTH];
  logic signed [WORD_W-1:0] z0_r, z1_r, a_r, b_r, res_r;
  logic signed [WORD_W-1:0] px_r, vx_r, p0_r, p3_r, wdata;
  logic [2*WORD_W-1:0]      prod_r;
  logic                     neg_r, nonpos_r;

  // divider
  logic [DVD_W-1:0]  dvd_r;
  logic [WORD_W:0]   rem_r;
  logic [WORD_W-1:0] den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W:0]   rem_sh;

  // output register
  logic [4*WORD_W-1:0] out_r;
  logic [1:0]          flags_r;
  logic                out_valid_r;

  function automatic logic [WORD_W-1:0] magn(logic signed [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_add(logic signed [WORD_W-1:0] a,
                                                       logic signed [WORD_W-1:0] b,
                                                       logic sub);
    logic [WORD_W:0] s;
    s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b}) : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
    if (s[WORD_W] != s[WORD_W-1]) begin
      return s[WORD_W] ? ~WMAX : WMAX;
    end
    return s[WORD_W-1:0];
  endfunction

  // clamp a magnitude against the signed limit and apply the sign
  function automatic logic signed [WORD_W-1:0] sat_mag(logic [DVD_W-1:0] m, logic neg);
    logic [DVD_W-1:0] lim;
    logic [DVD_W-1:0] v;
    lim = {{(DVD_W-WORD_W){1'b0}}, WMAX} + {{(DVD_W-1){1'b0}}, neg};
    v   = (m > lim) ? lim : m;
    return neg ? (~v[WORD_W-1:0] + 1'b1) : v[WORD_W-1:0];
  endfunction

  function automatic logic signed [WORD_W-1:0] src(logic [ADDR_W-1:0] a,
                                                   logic signed [WORD_W-1:0] m);
    case (a)
      A_ZERO:  return '0;
      A_DT:    return {{(WORD_W-16){1'b0}}, dt_r};
      A_Q:     return {1'b0, q_r};
      A_R:     return {1'b0, r_r};
      A_IV:    return {1'b0, iv_r};
      A_Z0:    return z0_r;
      A_Z1:    return z1_r;
      default: return m;
    endcase
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= 16'd6554;
      q_r  <= 31'd655;
      r_r  <= 31'd655;
      iv_r <= 31'd6553600;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_STEP_TIME:  dt_r <= cfg_wdata[15:0];
        CFG_PROC_NOISE: q_r  <= cfg_wdata[WORD_W-2:0];
        CFG_MEAS_NOISE: r_r  <= cfg_wdata[WORD_W-2:0];
        CFG_INIT_VAR:   iv_r <= cfg_wdata[WORD_W-2:0];
        default: ;
      endcase
    end
  end

  // measurement capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      z0_r <= in_word[WORD_W-1:0];
      z1_r <= in_word[2*WORD_W-1:WORD_W];
    end
  end

  // operand read, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      a_r <= src(cmd.src_a, mem_r[cmd.src_a < MEM_DEPTH ? cmd.src_a : '0]);
      b_r <= src(cmd.src_b, mem_r[cmd.src_b < MEM_DEPTH ? cmd.src_b : '0]);
    end
  end

  assign rem_sh = {rem_r[WORD_W-1:0], dvd_r[DVD_W-1]};

  // execute: add, subtract, multiply, divide
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (cmd.op)
        OP_ADD: res_r <= sat_add(a_r, b_r, 1'b0);
        OP_SUB: res_r <= sat_add(a_r, b_r, 1'b1);
        OP_MUL: begin
          prod_r <= magn(a_r) * magn(b_r);
          neg_r  <= a_r[WORD_W-1] ^ b_r[WORD_W-1];
        end
        default: begin
          dvd_r <= {magn(a_r), {FRAC_W{1'b0}}};
          den_r <= b_r;
          rem_r <= '0;
          neg_r <= a_r[WORD_W-1];
        end
      endcase
    end
    if (cmd.msat) begin
      res_r <= sat_mag(prod_r[FRAC_W +: DVD_W], neg_r);
    end
    if (cmd.div_step && cnt_r != '0) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= rem_sh - {1'b0, den_r};
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  // divider step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec && cmd.op == OP_DIV) begin
      cnt_r <= CNT_W'(DVD_W);
    end else if (cmd.div_step && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign wdata = (cmd.op == OP_DIV) ? sat_mag(dvd_r, neg_r) : res_r;

  // write-back and state shadows for the output
  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      mem_r[cmd.dst < MEM_DEPTH ? cmd.dst : '0] <= wdata;
      nonpos_r <= wdata[WORD_W-1] | (wdata == '0);
      if (cmd.dst == A_PX) px_r <= wdata;
      if (cmd.dst == A_VX) vx_r <= wdata;
      if (cmd.dst == A_P0) p0_r <= wdata;
      if (cmd.dst == A_P3) p3_r <= wdata;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r   <= {p3_r, p0_r, vx_r, px_r};
      flags_r <= {cmd.singular, cmd.first};
    end
  end

  assign status.div_done = (cnt_r == '0);
  assign status.nonpos   = nonpos_r;
  assign status.out_free = !out_valid_r || out_ready;
  assign out_word        = out_r;
  assign out_flags       = flags_r;
  assign out_valid       = out_valid_r;

endmodule

>>> hw/rtl/kalman_filter_2state_pos_vel_core.sv
// top level of the two-state position and velocity kalman filter
// Usage:
//   in_*  : one word per measurement, tdata = {meas_vel, meas_pos}, signed Q16.16.
//   out_* : one word per measurement, tdata = {var_vel, var_pos, est_vel, est_pos},
//           tuser = {singular_flag, first_sample}.
//   cfg_* : register writes (0 step time, 1 process noise, 2 measurement noise,
//           3 initial variance); always ready, write only while the core is idle.
// Datapath: a word runs through a microcoded sequence on one shared adder, one
//   32x32 multiplier and a bit-serial 48-step divider. Add/sub steps pass
//   through operand read, execute and write-back, multiplies add a saturation
//   state and divides step the divider until it is done. The first word after
//   reset only loads the state and a singular innovation ends the sequence
//   early. A new word is accepted only once the previous sequence has finished.
// Reset: state cleared, registers at their defaults, the next word only loads
//   the state. When the receiver stalls, one finished result waits in the
//   output register and the core may take and process the next word, holding
//   its result until the output register frees up.
module kalman_filter_2state_pos_vel_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // meas_pos [31:0], meas_vel [63:32]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // est_pos, est_vel, var_pos, var_vel, 32 bits each
  output logic [1:0]   out_tuser,  // first_sample [0], singular_flag [1]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import kf_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    idle;

  assign in_tready = idle;
  assign cfg_ready = 1'b1;

  // controller
  kf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && idle),
    .idle    (idle),
    .cmd     (cmd),
    .status  (status)
  );

  // datapath
  kf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_word   (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_word  (out_tdata),
    .out_flags (out_tuser),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

endmodule
